[src/rts_pkg.sv]
// Package for the rigid transform sanitizer: word widths, word structs,
// sequencer states and small fixed-point helpers. No dependencies.
package rts_pkg;

  localparam int FRAC_BITS = 32;
  localparam int INT_BITS  = 8;
  localparam int W         = INT_BITS + FRAC_BITS;
  localparam int HALF      = W / 2;
  localparam int ACC_W     = 2 * W + 4;
  localparam int DN_W      = W + FRAC_BITS + 2;
  localparam int STEP_W    = $clog2(DN_W);
  localparam int CFG_W     = 32;
  localparam int LIM_W     = 5;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] VMAX_A = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] VMIN_A = ~VMAX_A;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);

  // Configuration register indexes.
  localparam logic [1:0] REG_ORTHO_TOL = 2'd0;
  localparam logic [1:0] REG_CONV_TOL  = 2'd1;
  localparam logic [1:0] REG_ITER_LIM  = 2'd2;

  typedef struct packed {
    logic signed [W-1:0] a_r0c0;
    logic signed [W-1:0] a_r0c1;
    logic signed [W-1:0] a_r0c2;
    logic signed [W-1:0] a_r1c0;
    logic signed [W-1:0] a_r1c1;
    logic signed [W-1:0] a_r1c2;
    logic signed [W-1:0] a_r2c0;
    logic signed [W-1:0] a_r2c1;
    logic signed [W-1:0] a_r2c2;
    logic signed [W-1:0] trans_x;
    logic signed [W-1:0] trans_y;
    logic signed [W-1:0] trans_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          row_index;
    logic signed [W-1:0] col_0;
    logic signed [W-1:0] col_1;
    logic signed [W-1:0] col_2;
    logic                last_row;
    logic                singular;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ORTHO_MAC, ST_ORTHO_CHK, ST_COF_MAC, ST_COF_WR, ST_DET_MAC,
    ST_DET_CHK, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_WR, ST_OUT
  } state_t;

  // Next index modulo three.
  function automatic logic [1:0] inc3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  // Flat element index of row r, column c.
  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] e);
    logic [1:0] c;
    case (e)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Round half up to the element format and saturate.
  function automatic logic signed [W-1:0] sat_rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = (a + RND_HALF) >>> FRAC_BITS;
    if (t > VMAX_A) return VMAX;
    if (t < VMIN_A) return VMIN;
    return t[W-1:0];
  endfunction

  // Negate with saturation of the most negative value.
  function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] v);
    return (v == VMIN) ? VMAX : -v;
  endfunction

endpackage

[src/rigid_transform_sanitizer_core.sv]
// Rigid transform sanitizer top level: orthonormality check and Newton polar
// iteration on one shared multiplier and a bit-serial divider.
// Depends on rts_pkg.
//
// Usage: present a word on in_data with start high while busy is low; it is
// taken at that edge and busy rises. The block first forms A^T*A, one
// partial product a cycle. A matrix that fails the check runs Newton
// iterations; each forms the nine cofactors, the determinant and nine
// restoring divisions, one quotient bit a cycle, which set the bulk of the
// latency. A final cofactor and determinant pass fixes handedness. No more
// iterations run than the iteration limit allows. The four result words
// (rows 0 to 2, then translation) come on out_data in an unbroken run, each
// marked by out_valid; the receiver takes each in its cycle and cannot
// stall. busy falls after the last word. Reset returns the sequencer to
// idle and the configuration registers to their defaults. Configuration
// words are taken at any time but are meant to be written only while the
// block is idle.
module rigid_transform_sanitizer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rts_pkg::in_word_t         in_data,
  output logic                      out_valid,
  output rts_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [rts_pkg::CFG_W-1:0] cfg_data
);

  localparam int W     = rts_pkg::W;
  localparam int HALF  = rts_pkg::HALF;
  localparam int ACC_W = rts_pkg::ACC_W;
  localparam int DN_W  = rts_pkg::DN_W;
  localparam int LAST_STEP = DN_W - 1;

  rts_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0] x_r [9];
  logic signed [W-1:0] x_nxt [9];
  logic signed [W-1:0] cf_r [9];
  logic signed [W-1:0] cf_nxt [9];
  logic signed [W-1:0] t_r [3];
  logic signed [W-1:0] t_nxt [3];
  logic signed [W-1:0] det_r, det_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [DN_W-1:0] n_r, n_nxt, q_r, q_nxt;
  logic [W:0] rem_r, rem_nxt;
  logic [rts_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [3:0] elem_r, elem_nxt;
  logic [1:0] k_r, k_nxt, row_r, row_nxt;
  logic half_r, half_nxt;
  logic [rts_pkg::LIM_W-1:0] it_r, it_nxt;
  logic fin_r, fin_nxt, sing_r, sing_nxt, chg_r, chg_nxt;
  logic [rts_pkg::CFG_W-1:0] ortho_tol_r, conv_tol_r;
  logic [rts_pkg::LIM_W-1:0] iter_lim_r;

  // Operand selection and the shared multiplier.
  logic signed [W-1:0] op_a, op_b;
  logic op_sub;
  logic [1:0] k_max, er, ec, er1, er2, ec1, ec2;
  logic signed [HALF:0] b_part;
  logic signed [W+HALF:0] mul_p;
  logic signed [ACC_W-1:0] term, mac_sum;

  // Checks, rounding and division datapath.
  logic signed [ACC_W-1:0] dev, dev_abs;
  logic [ACC_W-1:0] tol_a;
  logic signed [W-1:0] rnd_val, cf_sel, ti, nx;
  logic [W-1:0] num_mag, den_mag;
  logic [DN_W-1:0] n_init;
  logic [W+1:0] rs, d_ext, rs_sub;
  logic q_neg;
  logic signed [W:0] sum1, diff;
  logic [W:0] dmag;
  logic elem_chg;

  assign busy      = (state_r != rts_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == rts_pkg::ST_OUT);

  // Result word from the current row counter.
  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == 2'd3);
    out_data.singular  = sing_r;
    if (row_r == 2'd3) begin
      out_data.col_0 = t_r[0];
      out_data.col_1 = t_r[1];
      out_data.col_2 = t_r[2];
    end else begin
      out_data.col_0 = x_r[rts_pkg::idx3(row_r, 2'd0)];
      out_data.col_1 = x_r[rts_pkg::idx3(row_r, 2'd1)];
      out_data.col_2 = x_r[rts_pkg::idx3(row_r, 2'd2)];
    end
  end

  // Operand routing for the multiply-accumulate steps.
  always_comb begin
    er  = rts_pkg::row_of(elem_r);
    ec  = rts_pkg::col_of(elem_r);
    er1 = rts_pkg::inc3(er);
    er2 = rts_pkg::inc3(er1);
    ec1 = rts_pkg::inc3(ec);
    ec2 = rts_pkg::inc3(ec1);
    op_sub = 1'b0;
    k_max  = 2'd2;
    case (state_r)
      rts_pkg::ST_COF_MAC: begin
        k_max = 2'd1;
        if (k_r == 2'd0) begin
          op_a = x_r[rts_pkg::idx3(er1, ec1)];
          op_b = x_r[rts_pkg::idx3(er2, ec2)];
        end else begin
          op_a   = x_r[rts_pkg::idx3(er1, ec2)];
          op_b   = x_r[rts_pkg::idx3(er2, ec1)];
          op_sub = 1'b1;
        end
      end
      rts_pkg::ST_DET_MAC: begin
        op_a = x_r[rts_pkg::idx3(2'd0, k_r)];
        op_b = cf_r[rts_pkg::idx3(2'd0, k_r)];
      end
      default: begin
        op_a = x_r[rts_pkg::idx3(k_r, er)];
        op_b = x_r[rts_pkg::idx3(k_r, ec)];
      end
    endcase
    // Low half unsigned, high half signed and weighted by 2^HALF.
    b_part  = half_r ? {op_b[W-1], op_b[W-1:HALF]} : {1'b0, op_b[HALF-1:0]};
    mul_p   = op_a * b_part;
    term    = half_r ? (ACC_W'(mul_p) <<< HALF) : ACC_W'(mul_p);
    mac_sum = op_sub ? acc_r - term : acc_r + term;
  end

  // Orthonormality deviation, rounding and divider datapath.
  always_comb begin
    dev     = (er == ec) ? acc_r - rts_pkg::ONE_SQ : acc_r;
    dev_abs = dev[ACC_W-1] ? -dev : dev;
    tol_a   = {{(ACC_W-rts_pkg::CFG_W-rts_pkg::FRAC_BITS){1'b0}}, ortho_tol_r,
               {rts_pkg::FRAC_BITS{1'b0}}};
    rnd_val = rts_pkg::sat_rnd(acc_r);
    cf_sel  = cf_r[elem_r];
    num_mag = cf_sel[W-1] ? W'(-cf_sel) : W'(cf_sel);
    den_mag = det_r[W-1] ? W'(-det_r) : W'(det_r);
    n_init  = (DN_W'(num_mag) << (rts_pkg::FRAC_BITS + 1)) + DN_W'(den_mag);
    rs      = {rem_r, n_r[DN_W-1]};
    d_ext   = {1'b0, den_mag, 1'b0};
    rs_sub  = rs - d_ext;
    q_neg   = cf_sel[W-1] ^ det_r[W-1];
    if (q_neg) begin
      ti = (q_r > (DN_W'(1) << (W - 1))) ? rts_pkg::VMIN : -q_r[W-1:0];
    end else begin
      ti = (|q_r[DN_W-1:W-1]) ? rts_pkg::VMAX : q_r[W-1:0];
    end
    sum1     = {x_r[elem_r][W-1], x_r[elem_r]} + {ti[W-1], ti} + (W+1)'(1);
    nx       = sum1[W:1];
    diff     = {nx[W-1], nx} - {x_r[elem_r][W-1], x_r[elem_r]};
    dmag     = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
    elem_chg = (dmag >= (W+1)'(conv_tol_r));
  end

  // Sequencer: next state and datapath register updates.
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    cf_nxt    = cf_r;
    t_nxt     = t_r;
    det_nxt   = det_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    elem_nxt  = elem_r;
    k_nxt     = k_r;
    half_nxt  = half_r;
    row_nxt   = row_r;
    it_nxt    = it_r;
    fin_nxt   = fin_r;
    sing_nxt  = sing_r;
    chg_nxt   = chg_r;
    case (state_r)
      rts_pkg::ST_IDLE: begin
        if (start) begin
          x_nxt[0] = in_data.a_r0c0;
          x_nxt[1] = in_data.a_r0c1;
          x_nxt[2] = in_data.a_r0c2;
          x_nxt[3] = in_data.a_r1c0;
          x_nxt[4] = in_data.a_r1c1;
          x_nxt[5] = in_data.a_r1c2;
          x_nxt[6] = in_data.a_r2c0;
          x_nxt[7] = in_data.a_r2c1;
          x_nxt[8] = in_data.a_r2c2;
          t_nxt[0] = in_data.trans_x;
          t_nxt[1] = in_data.trans_y;
          t_nxt[2] = in_data.trans_z;
          acc_nxt  = '0;
          elem_nxt = '0;
          k_nxt    = '0;
          half_nxt = 1'b0;
          sing_nxt = 1'b0;
          it_nxt   = '0;
          row_nxt  = '0;
          state_nxt = rts_pkg::ST_ORTHO_MAC;
        end
      end
      rts_pkg::ST_ORTHO_MAC, rts_pkg::ST_COF_MAC, rts_pkg::ST_DET_MAC: begin
        acc_nxt  = mac_sum;
        half_nxt = ~half_r;
        if (half_r) begin
          if (k_r == k_max) begin
            k_nxt = '0;
            case (state_r)
              rts_pkg::ST_ORTHO_MAC: state_nxt = rts_pkg::ST_ORTHO_CHK;
              rts_pkg::ST_COF_MAC:   state_nxt = rts_pkg::ST_COF_WR;
              default:               state_nxt = rts_pkg::ST_DET_CHK;
            endcase
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      rts_pkg::ST_ORTHO_CHK: begin
        acc_nxt = '0;
        if (dev_abs >= $signed(tol_a)) begin
          elem_nxt  = '0;
          fin_nxt   = (iter_lim_r == '0);
          state_nxt = rts_pkg::ST_COF_MAC;
        end else if (elem_r == 4'd8) begin
          state_nxt = rts_pkg::ST_OUT;
        end else begin
          elem_nxt  = elem_r + 4'd1;
          state_nxt = rts_pkg::ST_ORTHO_MAC;
        end
      end
      rts_pkg::ST_COF_WR: begin
        acc_nxt = '0;
        cf_nxt[elem_r] = rnd_val;
        if (elem_r == 4'd8) begin
          elem_nxt  = '0;
          state_nxt = rts_pkg::ST_DET_MAC;
        end else begin
          elem_nxt  = elem_r + 4'd1;
          state_nxt = rts_pkg::ST_COF_MAC;
        end
      end
      rts_pkg::ST_DET_CHK: begin
        acc_nxt = '0;
        det_nxt = rnd_val;
        if (fin_r) begin
          // Handedness fix: a negative determinant flips row 0.
          if (rnd_val[W-1]) begin
            x_nxt[0] = rts_pkg::sat_neg(x_r[0]);
            x_nxt[1] = rts_pkg::sat_neg(x_r[1]);
            x_nxt[2] = rts_pkg::sat_neg(x_r[2]);
          end
          state_nxt = rts_pkg::ST_OUT;
        end else if (rnd_val == '0) begin
          sing_nxt  = 1'b1;
          state_nxt = rts_pkg::ST_OUT;
        end else begin
          chg_nxt   = 1'b0;
          elem_nxt  = '0;
          state_nxt = rts_pkg::ST_DIV_INIT;
        end
      end
      rts_pkg::ST_DIV_INIT: begin
        n_nxt     = n_init;
        q_nxt     = '0;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = rts_pkg::ST_DIV_RUN;
      end
      rts_pkg::ST_DIV_RUN: begin
        // One restoring step: one quotient bit a cycle.
        n_nxt = {n_r[DN_W-2:0], 1'b0};
        if (rs >= d_ext) begin
          rem_nxt = rs_sub[W:0];
          q_nxt   = {q_r[DN_W-2:0], 1'b1};
        end else begin
          rem_nxt = rs[W:0];
          q_nxt   = {q_r[DN_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == rts_pkg::STEP_W'(LAST_STEP)) begin
          state_nxt = rts_pkg::ST_DIV_WR;
        end
      end
      rts_pkg::ST_DIV_WR: begin
        x_nxt[elem_r] = nx;
        chg_nxt = chg_r | elem_chg;
        if (elem_r == 4'd8) begin
          it_nxt    = it_r + 1'b1;
          fin_nxt   = !(chg_r | elem_chg) || ((it_r + 1'b1) == iter_lim_r);
          elem_nxt  = '0;
          state_nxt = rts_pkg::ST_COF_MAC;
        end else begin
          elem_nxt  = elem_r + 4'd1;
          state_nxt = rts_pkg::ST_DIV_INIT;
        end
      end
      rts_pkg::ST_OUT: begin
        row_nxt = row_r + 2'd1;
        if (row_r == 2'd3) begin
          state_nxt = rts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rts_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ortho_tol_r <= rts_pkg::CFG_W'(4295);
      conv_tol_r  <= rts_pkg::CFG_W'(4);
      iter_lim_r  <= rts_pkg::LIM_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rts_pkg::REG_ORTHO_TOL: ortho_tol_r <= cfg_data;
        rts_pkg::REG_CONV_TOL:  conv_tol_r  <= cfg_data;
        rts_pkg::REG_ITER_LIM:  iter_lim_r  <= cfg_data[rts_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r <= '0;
      k_r    <= '0;
      half_r <= 1'b0;
      row_r  <= '0;
      it_r   <= '0;
      step_r <= '0;
      fin_r  <= 1'b0;
      sing_r <= 1'b0;
      chg_r  <= 1'b0;
    end else begin
      elem_r <= elem_nxt;
      k_r    <= k_nxt;
      half_r <= half_nxt;
      row_r  <= row_nxt;
      it_r   <= it_nxt;
      step_r <= step_nxt;
      fin_r  <= fin_nxt;
      sing_r <= sing_nxt;
      chg_r  <= chg_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    cf_r  <= cf_nxt;
    t_r   <= t_nxt;
    det_r <= det_nxt;
    acc_r <= acc_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  // The last result word is followed by the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |=> !busy)
    else $error("block still busy after last row");

  // Result words come as an unbroken run of four.
  a_rows_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |=> out_valid)
    else $error("gap in result rows");

  // An accepted word makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("start not taken");

  // The divider never runs past its last step.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rts_pkg::ST_DIV_RUN |-> step_r <= rts_pkg::STEP_W'(LAST_STEP))
    else $error("divider step out of range");

  // Iteration count never passes the limit before results go out.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rts_pkg::ST_DIV_INIT |-> it_r < iter_lim_r)
    else $error("iteration past limit");

endmodule
